[rtl/plri_pkg.sv]
`default_nettype none

package plri_pkg;

	localparam int SLOT_W = 6;

	typedef logic [1:0] reg_index_t;

	localparam reg_index_t REG_LOSS_INTERVAL    = 2'd0;
	localparam reg_index_t REG_LOSS_BURST       = 2'd1;
	localparam reg_index_t REG_REORDER_INTERVAL = 2'd2;
	localparam reg_index_t REG_REORDER_BURST    = 2'd3;

	typedef logic [1:0] cmd_kind_t;

	localparam cmd_kind_t CMD_PASS   = 2'd0;
	localparam cmd_kind_t CMD_HOLD   = 2'd1;
	localparam cmd_kind_t CMD_REPLAY = 2'd2;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [SLOT_W-1:0]  slot;
		logic [15:0]        length;
		logic [31:0]        address;
		logic [15:0]        port;
		logic [31:0]        ip;
	} cmd_t;

endpackage

`default_nettype wire

[rtl/plri_ifs.sv]
`default_nettype none

interface plri_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

interface plri_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] payload_address;
	logic [15:0] payload_length;
	logic [31:0] dest_ip;
	logic [15:0] dest_port;

	modport source (output valid, output payload_address, output payload_length,
		output dest_ip, output dest_port, input ready);
	modport sink (input valid, input payload_address, input payload_length,
		input dest_ip, input dest_port, output ready);
endinterface

interface plri_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_address;
	logic [15:0] out_length;
	logic [31:0] out_ip;
	logic [15:0] out_port;
	logic        reordered;
	logic        last_of_run;

	modport source (output valid, output out_address, output out_length, output out_ip,
		output out_port, output reordered, output last_of_run, input ready);
	modport sink (input valid, input out_address, input out_length, input out_ip,
		input out_port, input reordered, input last_of_run, output ready);
endinterface

`default_nettype wire

[rtl/plri_front.sv]
`default_nettype none

module plri_front import plri_pkg::*; #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	plri_cfg_if.sink    cfg,
	plri_in_if.sink     ingress,
	output logic        push,
	output cmd_t        push_cmd,
	input  logic        full
);

	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	logic [31:0]       loss_interval_q;
	logic [31:0]       loss_burst_q;
	logic [31:0]       reorder_interval_q;
	logic [6:0]        reorder_burst_q;
	logic [31:0]       loss_count_q;
	logic [31:0]       loss_dropped_q;
	logic [31:0]       reorder_count_q;
	logic [FILL_W-1:0] fill_q;

	logic              accept;
	logic [31:0]       loss_dec;
	logic              loss_hit;
	logic [31:0]       loss_eff;
	logic [31:0]       dropped_nx;
	logic              loss_end;
	logic [31:0]       reo_dec;
	logic              reo_hit;
	logic [7:0]        reo_eff;
	logic [ADDR_W-1:0] slot;
	logic [7:0]        fill_nx;
	logic              reo_end;

	assign ingress.ready = !full;
	assign cfg.ready     = 1'b1;
	assign accept        = ingress.valid && !full;

	always_comb begin
		loss_dec   = (loss_count_q != 32'd0) ? loss_count_q - 32'd1 : 32'd0;
		loss_hit   = (loss_interval_q != 32'd0) && (loss_dec == 32'd0);
		loss_eff   = (loss_burst_q != 32'd0) ? loss_burst_q : 32'd1;
		dropped_nx = loss_dropped_q + 32'd1;
		loss_end   = dropped_nx >= loss_eff;

		reo_dec = (reorder_count_q != 32'd0) ? reorder_count_q - 32'd1 : 32'd0;
		reo_hit = !loss_hit && (reorder_interval_q != 32'd0) && (reo_dec == 32'd0);
		reo_eff = {1'b0, reorder_burst_q};
		if (reo_eff == 8'd0) begin
			reo_eff = 8'd1;
		end
		if (reo_eff > 8'(QUEUE_DEPTH)) begin
			reo_eff = 8'(QUEUE_DEPTH);
		end
		if (fill_q >= FILL_W'(QUEUE_DEPTH)) begin
			slot = ADDR_W'(QUEUE_DEPTH - 1);
		end else begin
			slot = fill_q[ADDR_W-1:0];
		end
		fill_nx = 8'(slot) + 8'd1;
		reo_end = fill_nx >= reo_eff;
	end

	always_comb begin
		push             = accept && !loss_hit;
		push_cmd.kind    = reo_hit ? (reo_end ? CMD_REPLAY : CMD_HOLD) : CMD_PASS;
		push_cmd.slot    = SLOT_W'(slot);
		push_cmd.length  = ingress.payload_length;
		push_cmd.address = ingress.payload_address;
		push_cmd.port    = ingress.dest_port;
		push_cmd.ip      = ingress.dest_ip;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loss_interval_q    <= '0;
			loss_burst_q       <= '0;
			reorder_interval_q <= '0;
			reorder_burst_q    <= '0;
			loss_count_q       <= '0;
			loss_dropped_q     <= '0;
			reorder_count_q    <= '0;
			fill_q             <= '0;
		end else begin
			if (accept) begin
				if (loss_interval_q != 32'd0) begin
					if (loss_hit && loss_end) begin
						loss_count_q   <= loss_interval_q;
						loss_dropped_q <= '0;
					end else if (loss_hit) begin
						loss_count_q   <= loss_dec;
						loss_dropped_q <= dropped_nx;
					end else begin
						loss_count_q <= loss_dec;
					end
				end
				if (!loss_hit && reorder_interval_q != 32'd0) begin
					if (reo_hit && reo_end) begin
						reorder_count_q <= reorder_interval_q;
						fill_q          <= '0;
					end else if (reo_hit) begin
						reorder_count_q <= reo_dec;
						fill_q          <= FILL_W'(fill_nx);
					end else begin
						reorder_count_q <= reo_dec;
					end
				end
			end
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_LOSS_INTERVAL: begin
						loss_interval_q <= cfg.data;
						loss_count_q    <= cfg.data;
						loss_dropped_q  <= '0;
					end
					REG_LOSS_BURST: begin
						loss_burst_q <= cfg.data;
					end
					REG_REORDER_INTERVAL: begin
						reorder_interval_q <= cfg.data;
						reorder_count_q    <= cfg.data;
					end
					REG_REORDER_BURST: begin
						reorder_burst_q <= cfg.data[6:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

[rtl/plri_queue.sv]
`default_nettype none

module plri_queue import plri_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	output logic head_valid,
	output cmd_t head_cmd,
	input  logic pop
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full       = count_q == 2'd2;
	assign head_valid = count_q != 2'd0;
	assign head_cmd   = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/plri_back.sv]
`default_nettype none

module plri_back import plri_pkg::*; #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  cmd_t        head_cmd,
	output logic        pop,
	plri_out_if.source  egress
);

	localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [95:0]       hold_mem [QUEUE_DEPTH];
	logic [95:0]       rd_data_q;
	logic [ADDR_W-1:0] rd_idx_q;
	logic [1:0]        state_q;
	logic [1:0]        state_d;

	logic              out_valid_q;
	logic [31:0]       out_address_q;
	logic [15:0]       out_length_q;
	logic [31:0]       out_ip_q;
	logic [15:0]       out_port_q;
	logic              out_reordered_q;
	logic              out_last_q;

	logic              out_free;
	logic              mem_we;
	logic              mem_re;
	logic [ADDR_W-1:0] rd_addr;
	logic              load_pass;
	logic              load_replay;
	logic              start_replay;

	assign out_free = !out_valid_q || egress.ready;

	always_comb begin
		pop          = 1'b0;
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		load_pass    = 1'b0;
		load_replay  = 1'b0;
		start_replay = 1'b0;
		rd_addr      = rd_idx_q;
		state_d      = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					unique case (head_cmd.kind)
						CMD_PASS: begin
							if (out_free) begin
								load_pass = 1'b1;
								pop       = 1'b1;
							end
						end
						CMD_HOLD: begin
							mem_we = 1'b1;
							pop    = 1'b1;
						end
						CMD_REPLAY: begin
							mem_we       = 1'b1;
							pop          = 1'b1;
							start_replay = 1'b1;
							state_d      = ST_READ;
						end
						default: begin
							pop = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				mem_re  = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					load_replay = 1'b1;
					if (rd_idx_q == '0) begin
						state_d = ST_IDLE;
					end else begin
						mem_re  = 1'b1;
						rd_addr = rd_idx_q - 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			hold_mem[head_cmd.slot[ADDR_W-1:0]] <= {head_cmd.length, head_cmd.address,
				head_cmd.port, head_cmd.ip};
		end
		if (mem_re) begin
			rd_data_q <= hold_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (start_replay) begin
			rd_idx_q <= head_cmd.slot[ADDR_W-1:0];
		end else if (load_replay && rd_idx_q != '0) begin
			rd_idx_q <= rd_idx_q - 1'b1;
		end
		if (load_pass) begin
			out_length_q    <= head_cmd.length;
			out_address_q   <= head_cmd.address;
			out_port_q      <= head_cmd.port;
			out_ip_q        <= head_cmd.ip;
			out_reordered_q <= 1'b0;
			out_last_q      <= 1'b1;
		end else if (load_replay) begin
			{out_length_q, out_address_q, out_port_q, out_ip_q} <= rd_data_q;
			out_reordered_q <= 1'b1;
			out_last_q      <= rd_idx_q == '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_pass || load_replay) begin
				out_valid_q <= 1'b1;
			end else if (egress.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign egress.valid       = out_valid_q;
	assign egress.out_address = out_address_q;
	assign egress.out_length  = out_length_q;
	assign egress.out_ip      = out_ip_q;
	assign egress.out_port    = out_port_q;
	assign egress.reordered   = out_reordered_q;
	assign egress.last_of_run = out_last_q;

endmodule

`default_nettype wire

[rtl/packet_loss_reorder_impairment_unit.sv]
// channel   direction  contents
// cfg       sink       index (0..3), data: loss/reorder interval and burst
// ingress   sink       payload_address, payload_length, dest_ip, dest_port
// egress    source     out_address, out_length, out_ip, out_port, reordered, last_of_run
//
// An ingress transfer is classified in the cycle it is taken; a passed packet reaches
// egress in the cycle after it leaves the two-entry command queue.
// A replay command passes the READ state for the first hold-memory read, then emits
// one result per cycle unless egress stalls; ingress stalls only once the queue is full.
// Dropped packets are accepted on ingress but leave no command.
// Reset clears control, counters and config; the hold memory and data are not cleared.
`default_nettype none

module packet_loss_reorder_impairment_unit import plri_pkg::*; #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	plri_cfg_if.sink    cfg,
	plri_in_if.sink     ingress,
	plri_out_if.source  egress
);

	logic push;
	cmd_t push_cmd;
	logic full;
	logic head_valid;
	cmd_t head_cmd;
	logic pop;

	plri_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.ingress  (ingress),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full)
	);

	plri_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop)
	);

	plri_back #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.egress     (egress)
	);

endmodule

`default_nettype wire

[rtl/plri_checker.sv]
`default_nettype none

module plri_checker (
	input logic clk,
	input logic arst_n,
	input logic eg_valid,
	input logic eg_ready,
	input logic eg_reordered,
	input logic eg_last
);

	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !eg_valid)
		else $error("egress valid during reset");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		eg_valid && !eg_ready |=> eg_valid)
		else $error("egress valid dropped while stalled");

	a_pass_last: assert property (@(posedge clk) disable iff (!arst_n)
		eg_valid && !eg_reordered |-> eg_last)
		else $error("passed packet not marked last");

	a_replay_run: assert property (@(posedge clk) disable iff (!arst_n)
		eg_valid && eg_ready && !eg_last |=> eg_valid && eg_reordered)
		else $error("replay run broken");

endmodule

bind packet_loss_reorder_impairment_unit plri_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.eg_valid     (egress.valid),
	.eg_ready     (egress.ready),
	.eg_reordered (egress.reordered),
	.eg_last      (egress.last_of_run)
);

`default_nettype wire
